/* rtl/ppu_pkg.sv */
// Shared types and constants for the palette pixel upscaler.
// No dependencies; every other file of the block but ppu_ram imports it.
package ppu_pkg;

    // Source image side, in pixels
    localparam int SRC_SIDE      = 128;
    localparam int COLOR_ENTRIES = 144;
    localparam int PAL_ENTRIES   = 16;
    localparam int COLOR_ADDR_W  = $clog2(COLOR_ENTRIES);

    localparam logic [7:0] CI_MASK = 8'h8f;

    // Screen offsets per mode
    localparam logic [8:0] X_FIT    = 9'((320 - 240) / 2);
    localparam logic [8:0] X_NATIVE = 9'((320 - SRC_SIDE) / 2);
    localparam logic [7:0] Y_NATIVE = 8'((240 - SRC_SIDE) / 2);
    localparam logic [8:0] X_DOUBLE = 9'((320 - 2 * SRC_SIDE) / 2);
    // Rows kept in doubled mode
    localparam logic [6:0] CROP_LO  = 7'd4;
    localparam logic [7:0] CROP_HI  = 8'(SRC_SIDE - 4);

    typedef enum logic [1:0] {
        ACT_PIXEL   = 2'd0,
        ACT_PALETTE = 2'd1,
        ACT_COLOR   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        MODE_FIT    = 2'd0,
        MODE_FILL   = 2'd1,
        MODE_NATIVE = 2'd2,
        MODE_DOUBLE = 2'd3
    } t_mode;

    // One block of screen writes for one pixel
    typedef struct packed {
        logic [8:0]  x0;
        logic [1:0]  ncols;
        logic [7:0]  y0;
        logic [1:0]  nrows;
        logic [15:0] color;
    } t_desc;

endpackage

/* rtl/palette_pixel_upscaler.sv */
// Palette pixel upscaler top level: front end, block queue and back end.
// Depends on ppu_pkg, ppu_front, ppu_queue, ppu_back.
//
// Input channel (i_in_valid / o_in_ready) takes pixel items and table loads.
// A palette-map load or colour-table load updates the table at the transfer
// and gives no output. A pixel item gives up to six screen writes on the
// output channel (o_out_valid / i_out_ready), row by row in ascending x,
// with o_last set on the final write of that pixel.
// One screen write per cycle leaves the back end while the receiver is ready;
// a pixel has up to six writes in fill mode, one in native mode. Loads and
// pixels without writes go in at one per cycle; the front end runs ahead
// through a four-deep block queue and stalls only when that queue is full.
// Scale mode is written through i_cfg_valid / o_cfg_ready; the user must
// write it only while idle, which the block itself does not enforce.
// Reset clears the palette map and sets fit mode; the colour table is not
// cleared and must be loaded before pixels use it. When the receiver stalls,
// the output register holds its write and the queue fills behind it.
module palette_pixel_upscaler (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_scale_mode,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_action,
    input  logic [6:0]  i_src_x,
    input  logic [6:0]  i_src_y,
    input  logic [3:0]  i_pixel_value,
    input  logic [7:0]  i_entry_index,
    input  logic [15:0] i_entry_value,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [8:0]  o_screen_x,
    output logic [7:0]  o_screen_y,
    output logic [15:0] o_color,
    output logic        o_last
);
    import ppu_pkg::*;

    logic  fq_valid;
    logic  fq_ready;
    t_desc fq_desc;
    logic  qb_valid;
    logic  qb_pop;
    t_desc qb_desc;

    assign o_cfg_ready = 1'b1;

    ppu_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_scale_mode (i_cfg_scale_mode),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_pixel_value    (i_pixel_value),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .o_desc_valid     (fq_valid),
        .o_desc           (fq_desc),
        .i_desc_ready     (fq_ready)
    );

    ppu_queue #(
        .DEPTH (4)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (fq_valid),
        .o_push_ready (fq_ready),
        .i_push_desc  (fq_desc),
        .o_pop_valid  (qb_valid),
        .i_pop        (qb_pop),
        .o_pop_desc   (qb_desc)
    );

    ppu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_desc_valid (qb_valid),
        .i_desc       (qb_desc),
        .o_pop        (qb_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_screen_x   (o_screen_x),
        .o_screen_y   (o_screen_y),
        .o_color      (o_color),
        .o_last       (o_last)
    );

endmodule

/* rtl/ppu_ram.sv */
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ppu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 144
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* rtl/ppu_front.sv */
// Front end: accepts items, applies table loads, looks up colours and works
// out the block of screen writes per pixel. Depends on ppu_pkg, ppu_ram.
module ppu_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_scale_mode,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [1:0]            i_action,
    input  logic [6:0]            i_src_x,
    input  logic [6:0]            i_src_y,
    input  logic [3:0]            i_pixel_value,
    input  logic [7:0]            i_entry_index,
    input  logic [15:0]           i_entry_value,
    output logic                  o_desc_valid,
    output ppu_pkg::t_desc        o_desc,
    input  logic                  i_desc_ready
);
    import ppu_pkg::*;

    t_mode       r_mode;
    logic [7:0]  r_palette [PAL_ENTRIES];
    logic        r_s1_valid;
    logic [8:0]  r_s1_x0;
    logic [1:0]  r_s1_ncols;
    logic [7:0]  r_s1_y0;
    logic [1:0]  r_s1_nrows;

    logic        accept;
    logic        emits;
    logic        pal_wr;
    logic        col_wr;
    logic [7:0]  ci;
    logic [15:0] rd_color;
    logic [1:0]  rows;
    logic [7:0]  y_scaled;
    logic [10:0] x15;
    logic [9:0]  x5;
    logic [10:0] y15;
    logic [8:0]  n_x0;
    logic [1:0]  n_ncols;
    logic [7:0]  n_y0;
    logic [1:0]  n_nrows;

    // Stage 1 moves on whenever its slot is free or the queue takes it
    assign o_in_ready = !r_s1_valid || i_desc_ready;
    assign accept     = i_in_valid && o_in_ready;

    assign pal_wr = accept && (i_action == ACT_PALETTE)
                    && (i_entry_index < 8'(PAL_ENTRIES));
    assign col_wr = accept && (i_action == ACT_COLOR)
                    && (i_entry_index < 8'(COLOR_ENTRIES));

    assign ci = r_palette[i_pixel_value] & CI_MASK;

    ppu_ram #(
        .WIDTH (16),
        .DEPTH (COLOR_ENTRIES)
    ) u_color_ram (
        .i_clk     (i_clk),
        .i_wr_en   (col_wr),
        .i_wr_addr (i_entry_index[COLOR_ADDR_W-1:0]),
        .i_wr_data (i_entry_value),
        .i_rd_en   (o_in_ready),
        .i_rd_addr (ci[COLOR_ADDR_W-1:0]),
        .o_rd_data (rd_color)
    );

    always_comb begin
        x15      = 11'(i_src_x) * 11'd15;
        x5       = 10'(i_src_x) * 10'd5;
        y15      = 11'(i_src_y) * 11'd15;
        y_scaled = y15[10:3];
        rows     = (i_src_y[2:0] != 3'd0) ? 2'd2 : 2'd1;
        emits    = (i_action == ACT_PIXEL)
                   && (8'(i_src_x) < 8'(SRC_SIDE)) && (8'(i_src_y) < 8'(SRC_SIDE));
        case (r_mode)
            MODE_FIT: begin
                n_x0    = X_FIT + 9'(x15[10:3]);
                n_ncols = 2'd2;
                n_y0    = y_scaled;
                n_nrows = rows;
            end
            MODE_FILL: begin
                n_x0    = x5[9:1];
                n_ncols = 2'd3;
                n_y0    = y_scaled;
                n_nrows = rows;
            end
            MODE_NATIVE: begin
                n_x0    = X_NATIVE + 9'(i_src_x);
                n_ncols = 2'd1;
                n_y0    = Y_NATIVE + 8'(i_src_y);
                n_nrows = 2'd1;
            end
            default: begin
                n_x0    = X_DOUBLE + {1'b0, i_src_x, 1'b0};
                n_ncols = 2'd2;
                n_y0    = {i_src_y - CROP_LO, 1'b0};
                n_nrows = 2'd2;
                if (i_src_y < CROP_LO || 8'(i_src_y) >= CROP_HI) begin
                    emits = 1'b0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FIT;
            r_s1_valid <= 1'b0;
            for (int i = 0; i < PAL_ENTRIES; i++) begin
                r_palette[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_mode <= t_mode'(i_cfg_scale_mode);
            end
            if (pal_wr) begin
                r_palette[i_entry_index[3:0]] <= i_entry_value[7:0];
            end
            if (o_in_ready) begin
                r_s1_valid <= accept && emits;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_x0    <= n_x0;
            r_s1_ncols <= n_ncols;
            r_s1_y0    <= n_y0;
            r_s1_nrows <= n_nrows;
        end
    end

    // Colour comes from the RAM read register, loaded together with stage 1
    assign o_desc_valid = r_s1_valid;
    assign o_desc.x0    = r_s1_x0;
    assign o_desc.ncols = r_s1_ncols;
    assign o_desc.y0    = r_s1_y0;
    assign o_desc.nrows = r_s1_nrows;
    assign o_desc.color = rd_color;

endmodule

/* rtl/ppu_queue.sv */
// Small FIFO of write blocks between front and back end.
// Depends on ppu_pkg.
module ppu_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push_valid,
    output logic           o_push_ready,
    input  ppu_pkg::t_desc i_push_desc,
    output logic           o_pop_valid,
    input  logic           i_pop,
    output ppu_pkg::t_desc o_pop_desc
);
    import ppu_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_desc            r_slot [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = r_count != CNT_W'(DEPTH);
    assign o_pop_valid  = r_count != '0;
    assign push         = i_push_valid && o_push_ready;
    assign pop          = i_pop && o_pop_valid;
    assign o_pop_desc   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_desc;
        end
    end

endmodule

/* rtl/ppu_back.sv */
// Back end: walks each write block row by row and drives the output register.
// Depends on ppu_pkg.
module ppu_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_desc_valid,
    input  ppu_pkg::t_desc i_desc,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic [8:0]     o_screen_x,
    output logic [7:0]     o_screen_y,
    output logic [15:0]    o_color,
    output logic           o_last
);
    import ppu_pkg::*;

    logic        r_busy;
    t_desc       r_cur;
    logic [1:0]  r_col;
    logic [1:0]  r_row;
    logic        r_o_valid;
    logic [8:0]  r_o_x;
    logic [7:0]  r_o_y;
    logic [15:0] r_o_color;
    logic        r_o_last;

    logic step;
    logic emit;
    logic col_end;
    logic cur_last;

    assign step     = !r_o_valid || i_out_ready;
    assign emit     = r_busy && step;
    assign col_end  = r_col == r_cur.ncols - 2'd1;
    assign cur_last = col_end && (r_row == r_cur.nrows - 2'd1);
    // Next block is loaded alongside the final write of the current one
    assign o_pop    = i_desc_valid && (!r_busy || (emit && cur_last));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && cur_last) begin
                r_busy <= 1'b0;
            end
            if (step) begin
                r_o_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur <= i_desc;
            r_col <= 2'd0;
            r_row <= 2'd0;
        end else if (emit) begin
            if (col_end) begin
                r_col <= 2'd0;
                r_row <= r_row + 2'd1;
            end else begin
                r_col <= r_col + 2'd1;
            end
        end
        if (emit) begin
            r_o_x     <= r_cur.x0 + 9'(r_col);
            r_o_y     <= r_cur.y0 + 8'(r_row);
            r_o_color <= r_cur.color;
            r_o_last  <= cur_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_screen_x  = r_o_x;
    assign o_screen_y  = r_o_y;
    assign o_color     = r_o_color;
    assign o_last      = r_o_last;

`ifndef ASSERT_OFF
    a_counters_in_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_col < r_cur.ncols) && (r_row < r_cur.nrows))
        else $error("block counters past block size");

    a_block_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> (r_cur.ncols != 2'd0) && (r_cur.nrows != 2'd0))
        else $error("empty write block loaded");

    a_open_block_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !r_o_last) |-> r_busy)
        else $error("pixel writes cut short");
`endif

endmodule

/* sim/testbench.sv */
// Testbench for palette_pixel_upscaler: a directed table, then random phases over every scale mode.
// Every screen write is checked field by field against a behavioural predictor or a typed-in value.
// Depends on ppu_pkg and the palette_pixel_upscaler RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import ppu_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam logic [7:0] CI_KEEP     = 8'h8f;
    localparam int         CYCLE_LIMIT = 200_000;
    localparam int         DRAIN_SLACK = 8;
    localparam int         MAX_REPORTS = 10;
    localparam int         PHASES      = 6;
    localparam int         PHASE_ITEMS = 70;

    localparam t_mode PHASE_MODE [PHASES] =
        '{MODE_FILL, MODE_FIT, MODE_DOUBLE, MODE_NATIVE, MODE_FILL, MODE_DOUBLE};
    localparam int PHASE_IN_IDLE  [PHASES] = '{30, 0, 50, 20, 30, 0};
    localparam int PHASE_OUT_IDLE [PHASES] = '{30, 40, 0, 20, 50, 0};

    typedef enum {R_ITEM, R_MODE} t_kind;
    typedef enum {BY_MODEL, NO_WRITE, ONE_WRITE} t_check;

    typedef struct {
        t_kind       kind;
        t_mode       mode;
        logic [1:0]  action;
        logic [6:0]  sx;
        logic [6:0]  sy;
        logic [3:0]  pv;
        logic [7:0]  idx;
        logic [15:0] val;
        t_check      check;
        logic [8:0]  wx;
        logic [7:0]  wy;
        logic [15:0] wc;
    } t_row;

    typedef struct {
        logic [8:0]  x;
        logic [7:0]  y;
        logic [15:0] colour;
        logic        last;
    } t_write;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_scale_mode;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_action;
    logic [6:0]  i_src_x;
    logic [6:0]  i_src_y;
    logic [3:0]  i_pixel_value;
    logic [7:0]  i_entry_index;
    logic [15:0] i_entry_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [8:0]  o_screen_x;
    logic [7:0]  o_screen_y;
    logic [15:0] o_color;
    logic        o_last;

    // Predictor state
    logic [7:0]  pal_map    [PAL_ENTRIES];
    logic [15:0] colour_tbl [COLOR_ENTRIES];
    bit          colour_set [COLOR_ENTRIES];
    t_mode       mode_now;
    t_write      pending_writes [$];

    int mismatches   = 0;
    int items_done   = 0;
    int cycle_count  = 0;
    int in_idle_pct  = 0;
    int out_idle_pct = 0;
    int hold_request = 0;
    int hold_left    = 0;
    int stall_left   = 0;

    // Native and fixed-position writes are typed in; multi-write rows go through the predictor
    t_row directed [28] = '{
        '{R_MODE, MODE_NATIVE, ACT_PIXEL, 0, 0, 0, 0, 'h0000, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_COLOR, 0, 0, 0, 0, 'h0000, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_COLOR, 0, 0, 0, 0, 'hffff, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 0, 0, 0, 0, 'h0000, ONE_WRITE, 96, 56, 'hffff},
        '{R_ITEM, MODE_FIT, ACT_COLOR, 0, 0, 0, 143, 'h1234, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PALETTE, 0, 0, 0, 15, 'hffff, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 127, 127, 15, 0, 'h0, ONE_WRITE, 223, 183, 'h1234},
        '{R_ITEM, MODE_FIT, ACT_PALETTE, 0, 0, 0, 16, 'h0001, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PALETTE, 0, 0, 0, 255, 'hffff, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_COLOR, 0, 0, 0, 144, 'hffff, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_COLOR, 0, 0, 0, 255, 'h0000, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_UNUSED, 127, 127, 15, 255, 'hffff, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 127, 0, 0, 0, 'h0, ONE_WRITE, 223, 56, 'hffff},
        // bits 6:4 of the palette byte are masked off, so this still selects entry 0
        '{R_ITEM, MODE_FIT, ACT_PALETTE, 0, 0, 0, 0, 'hab70, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 5, 9, 0, 0, 'h0, ONE_WRITE, 101, 65, 'hffff},
        '{R_MODE, MODE_FIT, ACT_PIXEL, 0, 0, 0, 0, 'h0000, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 0, 0, 15, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 127, 127, 0, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 1, 1, 15, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_MODE, MODE_FILL, ACT_PIXEL, 0, 0, 0, 0, 'h0000, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 0, 0, 0, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 127, 127, 15, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 3, 7, 0, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_MODE, MODE_DOUBLE, ACT_PIXEL, 0, 0, 0, 0, 'h0000, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 0, 3, 0, 0, 'h0, NO_WRITE, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 0, 4, 15, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 127, 123, 0, 0, 'h0, BY_MODEL, 0, 0, 'h0},
        '{R_ITEM, MODE_FIT, ACT_PIXEL, 5, 124, 15, 0, 'h0, NO_WRITE, 0, 0, 'h0}
    };

    palette_pixel_upscaler uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_scale_mode (i_cfg_scale_mode),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_action         (i_action),
        .i_src_x          (i_src_x),
        .i_src_y          (i_src_y),
        .i_pixel_value    (i_pixel_value),
        .i_entry_index    (i_entry_index),
        .i_entry_value    (i_entry_value),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_screen_x       (o_screen_x),
        .o_screen_y       (o_screen_y),
        .o_color          (o_color),
        .o_last           (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Appends one expected screen write to the tail of the queue
    function automatic void add_write(t_write w);
        pending_writes.insert(pending_writes.size(), w);
    endfunction

    // Updates the tables and, when asked, queues the screen writes a transfer causes
    function automatic void apply_item(t_row r, bit emit);
        int unsigned sx, sy, x0, y0, ncols, nrows, i, j;
        logic [7:0]  ci;
        logic [15:0] c;
        sx = r.sx;
        sy = r.sy;
        ncols = 0;
        nrows = 0;
        x0 = 0;
        y0 = 0;
        case (r.action)
            ACT_PALETTE: begin
                if (r.idx < PAL_ENTRIES) pal_map[r.idx[3:0]] = r.val[7:0];
            end
            ACT_COLOR: begin
                if (r.idx < COLOR_ENTRIES) begin
                    colour_tbl[r.idx] = r.val;
                    colour_set[r.idx] = 1'b1;
                end
            end
            ACT_PIXEL: begin
                if (sx < SRC_SIDE && sy < SRC_SIDE) begin
                    ci = pal_map[r.pv] & CI_KEEP;
                    c = colour_tbl[ci];
                    nrows = (sy % 8 != 0) ? 2 : 1;
                    case (mode_now)
                        MODE_FIT: begin
                            x0 = 40 + (1875 * sx) / 1000;
                            ncols = 2;
                            y0 = (15 * sy) / 8;
                        end
                        MODE_FILL: begin
                            x0 = (25 * sx) / 10;
                            ncols = 3;
                            y0 = (15 * sy) / 8;
                        end
                        MODE_NATIVE: begin
                            x0 = (320 - SRC_SIDE) / 2 + sx;
                            y0 = (240 - SRC_SIDE) / 2 + sy;
                            ncols = 1;
                            nrows = 1;
                        end
                        default: begin
                            // only source rows 4 .. side-5 survive the crop
                            if (sy >= 4 && sy + 4 < SRC_SIDE) begin
                                x0 = (320 - 2 * SRC_SIDE) / 2 + 2 * sx;
                                y0 = 2 * (sy - 4);
                                ncols = 2;
                                nrows = 2;
                            end else begin
                                nrows = 0;
                            end
                        end
                    endcase
                    if (emit) begin
                        for (j = 0; j < nrows; j++)
                            for (i = 0; i < ncols; i++)
                                add_write(t_write'{9'(x0 + i), 8'(y0 + j), c,
                                    (j == nrows - 1 && i == ncols - 1)});
                    end
                end
            end
            default: ;
        endcase
    endfunction

    function automatic t_row random_item();
        t_row        r;
        int unsigned pick;
        r.kind   = R_ITEM;
        r.mode   = mode_now;
        r.check  = BY_MODEL;
        r.action = ACT_PIXEL;
        r.sx     = 7'($urandom);
        r.sy     = 7'($urandom);
        r.pv     = 4'($urandom);
        r.idx    = 8'($urandom);
        r.val    = 16'($urandom);
        r.wx     = '0;
        r.wy     = '0;
        r.wc     = '0;
        pick = $urandom_range(99);
        if (pick < 72) begin
            r.action = ACT_PIXEL;
            if ($urandom_range(9) == 0) r.sx = $urandom_range(1) ? 7'd127 : 7'd0;
            if ($urandom_range(9) == 0) begin
                r.sy = $urandom_range(1) ? 7'd127 : 7'd0;
            end else if (mode_now == MODE_DOUBLE && $urandom_range(5) == 0) begin
                // hug the crop boundaries
                r.sy = $urandom_range(1) ? 7'($urandom_range(127, 122)) : 7'($urandom_range(5));
            end
        end else if (pick < 84) begin
            r.action = ACT_PALETTE;
            if ($urandom_range(9) != 0) r.idx = 8'($urandom_range(15));
        end else if (pick < 96) begin
            r.action = ACT_COLOR;
            // mostly entries a masked palette byte can reach
            if ($urandom_range(4) != 0)
                r.idx = 8'($urandom_range(1) * 128 + $urandom_range(15));
        end else begin
            r.action = ACT_UNUSED;
        end
        return r;
    endfunction

    task automatic offer(t_row r);
        i_in_valid    <= 1'b1;
        i_action      <= r.action;
        i_src_x       <= r.sx;
        i_src_y       <= r.sy;
        i_pixel_value <= r.pv;
        i_entry_index <= r.idx;
        i_entry_value <= r.val;
        do @(posedge i_clk); while (!o_in_ready);
        apply_item(r, r.check == BY_MODEL);
        if (r.check == ONE_WRITE)
            add_write(t_write'{r.wx, r.wy, r.wc, 1'b1});
        if (!(r.action == ACT_UNUSED || (r.action == ACT_PALETTE && r.idx >= PAL_ENTRIES)
              || (r.action == ACT_COLOR && r.idx >= COLOR_ENTRIES)))
            items_done++;
    endtask

    // A pixel must never read a colour entry that has not been loaded
    task automatic feed(t_row r);
        t_row       load;
        logic [7:0] ci;
        ci = pal_map[r.pv] & CI_KEEP;
        if (r.action == ACT_PIXEL && !colour_set[ci]) begin
            load = r;
            load.action = ACT_COLOR;
            load.idx = ci;
            load.val = 16'($urandom);
            load.check = BY_MODEL;
            offer(load);
        end
        offer(r);
    endtask

    task automatic sender_gap();
        if (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(5, 1)) @(posedge i_clk);
        end
    endtask

    // Drain every expected write, then allow for pixels still in flight that write nothing
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_writes.size() != 0);
        repeat (DRAIN_SLACK) @(posedge i_clk);
    endtask

    task automatic set_mode(t_mode m);
        i_cfg_valid      <= 1'b1;
        i_cfg_scale_mode <= m;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mode_now = m;
    endtask

    // Output side: random stall bursts plus the occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n || hold_left > 0 || stall_left > 0) begin
            i_out_ready <= 1'b0;
            if (hold_left > 0) hold_left--;
            else if (stall_left > 0) stall_left--;
        end else if (out_idle_pct != 0 && $urandom_range(99) < out_idle_pct) begin
            i_out_ready <= 1'b0;
            stall_left = $urandom_range(4);
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin : check_writes
        t_write want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_writes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected write: x=%0d y=%0d colour=%h last=%b",
                             o_screen_x, o_screen_y, o_color, o_last);
            end else begin
                want = pending_writes.pop_front();
                if (o_screen_x !== want.x || o_screen_y !== want.y
                    || o_color !== want.colour || o_last !== want.last) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("write mismatch: expected x=%0d y=%0d colour=%h last=%b, %s",
                                 want.x, want.y, want.colour, want.last,
                                 $sformatf("got x=%0d y=%0d colour=%h last=%b",
                                           o_screen_x, o_screen_y, o_color, o_last));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        t_row r;
        int   base;
        int   p;
        bit   held;
        bit   paused;
        held = 1'b0;
        paused = 1'b0;
        i_rst_n          <= 1'b0;
        i_cfg_valid      <= 1'b0;
        i_cfg_scale_mode <= MODE_FIT;
        i_in_valid       <= 1'b0;
        i_action         <= ACT_PIXEL;
        i_src_x          <= '0;
        i_src_y          <= '0;
        i_pixel_value    <= '0;
        i_entry_index    <= '0;
        i_entry_value    <= '0;
        i_out_ready      <= 1'b0;
        mode_now = MODE_FIT;
        foreach (pal_map[k]) pal_map[k] = 8'h00;
        foreach (colour_set[k]) colour_set[k] = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        in_idle_pct = 25;
        out_idle_pct = 25;
        foreach (directed[k]) begin
            if (directed[k].kind == R_MODE) begin
                settle();
                set_mode(directed[k].mode);
            end else begin
                sender_gap();
                feed(directed[k]);
            end
        end

        for (p = 0; p < PHASES; p++) begin
            settle();
            set_mode(PHASE_MODE[p]);
            in_idle_pct = PHASE_IN_IDLE[p];
            out_idle_pct = PHASE_OUT_IDLE[p];
            base = items_done;
            while (items_done - base < PHASE_ITEMS) begin
                if (p == 0 && !held && items_done - base >= 20) begin
                    // back-to-back fill-mode pixels against a stalled receiver
                    held = 1'b1;
                    hold_request = 80;
                    repeat (24) begin
                        r = random_item();
                        r.action = ACT_PIXEL;
                        feed(r);
                    end
                end
                if (p == 2 && !paused && items_done - base >= 40) begin
                    paused = 1'b1;
                    settle();
                end
                sender_gap();
                feed(random_item());
            end
        end

        settle();
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
